@@ design/lsdg_pkg.sv @@
// Shared types, constants and helpers for the load-stepped DVFS governor.
// No dependencies; the table, remainder unit and top level refer to it by scoped names.

package lsdg_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = 4;
    localparam int LEN_W       = 5;
    localparam int KHZ_W       = 24;
    localparam int CNT_W       = 8;
    localparam int CFG_W       = 28;

    localparam logic [23:0] RESP_RESET   = 24'd1113600;
    localparam logic [27:0] THRESH_RESET = 28'd126821190;
    localparam logic [11:0] PUMP_RESET   = 12'd1106;

    typedef enum logic [2:0] {
        CFG_RESP    = 3'd0,
        CFG_THRESH  = 3'd1,
        CFG_PUMP    = 3'd2,
        CFG_UP_DIV  = 3'd3,
        CFG_DN_DIV  = 3'd4,
        CFG_LO_IDX  = 3'd5,
        CFG_HI_IDX  = 3'd6,
        CFG_TBL_LEN = 3'd7
    } cfg_idx_t;

    // table write port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [KHZ_W-1:0] data;
        logic             valid;
    } tbl_wr_t;

    // modulo unit request and response
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } mod_rsp_t;

    // Clamp a pump step field to 1..6.
    function automatic logic [2:0] step_sat(input logic [2:0] s);
        logic [2:0] r;
        r = s;
        if (s == 3'd0) r = 3'd1;
        if (s == 3'd7) r = 3'd6;
        return r;
    endfunction

endpackage

@@ design/lsdg_table.sv @@
// Frequency table: entry memory with a registered read port and reset-cleared valid bits.
// Depends on lsdg_pkg.

module lsdg_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lsdg_pkg::tbl_wr_t             wr,
    input  logic [lsdg_pkg::IDX_W-1:0]    rd_addr,
    output logic [lsdg_pkg::KHZ_W-1:0]    rd_data,
    output logic [lsdg_pkg::TABLE_DEPTH-1:0] vld_bits
);

    logic [lsdg_pkg::KHZ_W-1:0]       freq_mem [lsdg_pkg::TABLE_DEPTH];
    logic [lsdg_pkg::KHZ_W-1:0]       rd_data_reg;
    logic [lsdg_pkg::TABLE_DEPTH-1:0] vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            freq_mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= freq_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr.en)
        begin
            vld_reg[wr.addr] <= wr.valid;
        end
    end

    assign rd_data  = rd_data_reg;
    assign vld_bits = vld_reg;

endmodule

@@ design/lsdg_mod_unit.sv @@
// Shared bit-serial remainder unit: a load step, then one restoring step per cycle for each of
// the eight dividend bits. Depends on lsdg_pkg. A divisor of zero acts as one.

module lsdg_mod_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  lsdg_pkg::mod_req_t req,
    output lsdg_pkg::mod_rsp_t rsp
);

    localparam int W = lsdg_pkg::CNT_W;

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] dvd_reg, dvd_next;
    logic [W-1:0] dvs_reg, dvs_next;
    logic [W:0]   shifted;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, dvd_reg[W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = (req.divisor == '0) ? W'(1) : req.divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = W'(shifted - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = shifted[W-1:0];
            end
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.rem_zero = (rem_reg == '0);

endmodule

@@ design/load_stepped_dvfs_governor.sv @@
// Load-stepped DVFS governor top level: configuration registers and the sample sequencer.
// Depends on lsdg_pkg, lsdg_table and lsdg_mod_unit.
//
// Input channel (in_valid/in_ready): op 1 writes frequency_khz and entry_valid into table
// slot entry_index and gives no result; op 0 is a load sample that gives exactly one
// result transaction on the output channel (out_valid/out_ready).
// A table write leaves in_ready high.
// A sample scans the first table_length entries, at most 16, one per cycle (a single memory
// read port); when a threshold is met it then runs the rate counter through a bit-serial
// remainder unit, and when that allows a step it reads the chosen entry. in_ready is low
// until the result is in the output register, so no new transaction is taken while a
// sample is in progress.
// The result sits in an output register: the next transaction is taken while it waits,
// and a sample that finishes while the receiver stalls holds in its last state until
// the output register frees up.
// Configuration is written through cfg_we/cfg_index/cfg_data with no wait; the user must
// write it only while the block is idle, as the block itself does not enforce this.
// Reset: registers take their default values, all table entries become invalid and
// both rate counters clear; table contents are undefined until written.

module load_stepped_dvfs_governor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [6:0]  load_percent,
    input  logic [23:0] frequency_khz,
    input  logic [3:0]  entry_index,
    input  logic        entry_valid,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        target_requested,
    output logic [23:0] target_khz,
    output logic [3:0]  new_index,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [27:0] cfg_data
);

    localparam int IW = lsdg_pkg::IDX_W;
    localparam int LW = lsdg_pkg::LEN_W;
    localparam int KW = lsdg_pkg::KHZ_W;
    localparam int CW = lsdg_pkg::CNT_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_MOD    = 7'b0001000,
        S_FETCH  = 7'b0010000,
        S_LOOKUP = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    // configuration
    logic [23:0] resp_reg;
    logic [27:0] thresh_reg;
    logic [11:0] pump_reg;
    logic [7:0]  up_div_reg;
    logic [7:0]  dn_div_reg;
    logic [3:0]  lo_idx_reg;
    logic [3:0]  hi_idx_reg;
    logic [4:0]  tbl_len_reg;

    state_t state_reg, state_next;
    logic [6:0]    load_reg, load_next;
    logic [KW-1:0] freq_reg, freq_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          found_reg, found_next;
    logic [LW-1:0] rd_cnt_reg, rd_cnt_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next;
    logic          up_mode_reg, up_mode_next;
    logic [CW-1:0] up_cnt_reg, up_cnt_next;
    logic [CW-1:0] dn_cnt_reg, dn_cnt_next;
    logic          res_req_reg, res_req_next;
    logic [KW-1:0] res_khz_reg, res_khz_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_req_reg, out_req_next;
    logic [KW-1:0] out_khz_reg, out_khz_next;
    logic [IW-1:0] out_idx_reg, out_idx_next;

    lsdg_pkg::tbl_wr_t  tbl_wr;
    lsdg_pkg::mod_req_t mod_req;
    lsdg_pkg::mod_rsp_t mod_rsp;
    logic [IW-1:0]                    rd_addr;
    logic [KW-1:0]                    rd_data;
    logic [lsdg_pkg::TABLE_DEPTH-1:0] vld_bits;

    logic          accept;
    logic [LW-1:0] used_len;
    logic          low_mode;
    logic [6:0]    raise_th, lower_th;
    logic [2:0]    up_step, dn_step;
    logic [CW-1:0] up_div, dn_div;
    logic          up_hit, dn_hit;
    logic          issue;
    logic [IW:0]   up_sum;
    logic [IW-1:0] dn_gap;
    logic          entry_hit;

    lsdg_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .vld_bits (vld_bits)
    );

    lsdg_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_reg    <= lsdg_pkg::RESP_RESET;
            thresh_reg  <= lsdg_pkg::THRESH_RESET;
            pump_reg    <= lsdg_pkg::PUMP_RESET;
            up_div_reg  <= 8'd1;
            dn_div_reg  <= 8'd1;
            lo_idx_reg  <= 4'd0;
            hi_idx_reg  <= 4'd15;
            tbl_len_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            case (lsdg_pkg::cfg_idx_t'(cfg_index))
                lsdg_pkg::CFG_RESP:    resp_reg    <= cfg_data[23:0];
                lsdg_pkg::CFG_THRESH:  thresh_reg  <= cfg_data;
                lsdg_pkg::CFG_PUMP:    pump_reg    <= cfg_data[11:0];
                lsdg_pkg::CFG_UP_DIV:  up_div_reg  <= cfg_data[7:0];
                lsdg_pkg::CFG_DN_DIV:  dn_div_reg  <= cfg_data[7:0];
                lsdg_pkg::CFG_LO_IDX:  lo_idx_reg  <= cfg_data[3:0];
                lsdg_pkg::CFG_HI_IDX:  hi_idx_reg  <= cfg_data[3:0];
                lsdg_pkg::CFG_TBL_LEN: tbl_len_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    assign tbl_wr.en    = accept && op;
    assign tbl_wr.addr  = entry_index;
    assign tbl_wr.data  = frequency_khz;
    assign tbl_wr.valid = entry_valid;

    assign rd_addr = (state_reg == S_SCAN) ? rd_cnt_reg[IW-1:0] : idx_reg;

    assign used_len = (tbl_len_reg > LW'(lsdg_pkg::TABLE_DEPTH))
                    ? LW'(lsdg_pkg::TABLE_DEPTH) : tbl_len_reg;
    assign low_mode = (freq_reg < resp_reg);
    assign raise_th = low_mode ? thresh_reg[20:14] : thresh_reg[6:0];
    assign lower_th = low_mode ? thresh_reg[27:21] : thresh_reg[13:7];
    assign up_step  = lsdg_pkg::step_sat(low_mode ? pump_reg[5:3]  : pump_reg[2:0]);
    assign dn_step  = lsdg_pkg::step_sat(low_mode ? pump_reg[11:9] : pump_reg[8:6]);
    assign up_div   = (up_div_reg == '0) ? CW'(1) : up_div_reg;
    assign dn_div   = (dn_div_reg == '0) ? CW'(1) : dn_div_reg;
    assign up_hit   = (load_reg >= raise_th) && (idx_reg < hi_idx_reg);
    assign dn_hit   = (load_reg < lower_th) && (idx_reg > lo_idx_reg);
    assign issue    = (rd_cnt_reg < used_len);
    assign up_sum   = {1'b0, idx_reg} + {2'b00, up_step};
    assign dn_gap   = idx_reg - lo_idx_reg;
    assign entry_hit = ({1'b0, idx_reg} < used_len) && vld_bits[idx_reg];

    assign mod_req.start    = (state_reg == S_DECIDE) && (up_hit || dn_hit);
    assign mod_req.dividend = up_hit ? up_cnt_reg : dn_cnt_reg;
    assign mod_req.divisor  = up_hit ? up_div_reg : dn_div_reg;

    always_comb
    begin
        state_next     = state_reg;
        load_next      = load_reg;
        freq_next      = freq_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        rd_cnt_next    = rd_cnt_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        up_mode_next   = up_mode_reg;
        up_cnt_next    = up_cnt_reg;
        dn_cnt_next    = dn_cnt_reg;
        res_req_next   = res_req_reg;
        res_khz_next   = res_khz_reg;
        out_valid_next = out_valid_reg;
        out_req_next   = out_req_reg;
        out_khz_next   = out_khz_reg;
        out_idx_next   = out_idx_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && !op)
                begin
                    load_next   = load_percent;
                    freq_next   = frequency_khz;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    rd_cnt_next = '0;
                    pend_next   = 1'b0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // compare the entry read last cycle, keep the first match
                if (pend_reg && !found_reg && vld_bits[pend_idx_reg]
                    && (rd_data == freq_reg))
                begin
                    found_next = 1'b1;
                    idx_next   = pend_idx_reg;
                end
                pend_next     = issue;
                pend_idx_next = rd_cnt_reg[IW-1:0];
                if (issue)
                begin
                    rd_cnt_next = rd_cnt_reg + LW'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                up_mode_next = up_hit;
                if (!up_hit && !dn_hit)
                begin
                    up_cnt_next  = CW'(1);
                    dn_cnt_next  = CW'(1);
                    res_req_next = 1'b0;
                    res_khz_next = '0;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_rsp.done)
                begin
                    if (mod_rsp.rem_zero)
                    begin
                        up_cnt_next = CW'(1);
                        dn_cnt_next = CW'(1);
                        if (up_mode_reg)
                        begin
                            idx_next = (up_sum <= {1'b0, hi_idx_reg})
                                     ? up_sum[IW-1:0] : hi_idx_reg;
                        end
                        else
                        begin
                            idx_next = (dn_gap >= {1'b0, dn_step})
                                     ? idx_reg - {1'b0, dn_step} : lo_idx_reg;
                        end
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        // pace the step: advance the counter or wrap it to one
                        if (up_mode_reg)
                        begin
                            up_cnt_next = (up_cnt_reg < up_div) ? up_cnt_reg + CW'(1) : CW'(1);
                        end
                        else
                        begin
                            dn_cnt_next = (dn_cnt_reg < dn_div) ? dn_cnt_reg + CW'(1) : CW'(1);
                        end
                        res_req_next = 1'b0;
                        res_khz_next = '0;
                        state_next   = S_DONE;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_LOOKUP;
            end
            S_LOOKUP:
            begin
                res_req_next = entry_hit;
                res_khz_next = entry_hit ? rd_data : '0;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_req_next   = res_req_reg;
                    out_khz_next   = res_khz_reg;
                    out_idx_next   = idx_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            found_reg     <= 1'b0;
            rd_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
            up_mode_reg   <= 1'b0;
            up_cnt_reg    <= '0;
            dn_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            found_reg     <= found_next;
            rd_cnt_reg    <= rd_cnt_next;
            pend_reg      <= pend_next;
            up_mode_reg   <= up_mode_next;
            up_cnt_reg    <= up_cnt_next;
            dn_cnt_reg    <= dn_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        load_reg     <= load_next;
        freq_reg     <= freq_next;
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        res_req_reg  <= res_req_next;
        res_khz_reg  <= res_khz_next;
        out_req_reg  <= out_req_next;
        out_khz_reg  <= out_khz_next;
        out_idx_reg  <= out_idx_next;
    end

    assign out_valid        = out_valid_reg;
    assign target_requested = out_req_reg;
    assign target_khz       = out_khz_reg;
    assign new_index        = out_idx_reg;

endmodule

@@ design/lsdg_checker.sv @@
// Port-level checks for the load-stepped DVFS governor, bound to the top level.
// Depends on load_stepped_dvfs_governor ports only.

module lsdg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        op,
    input logic        out_valid,
    input logic        out_ready,
    input logic        target_requested,
    input logic [23:0] target_khz,
    input logic [3:0]  new_index
);

    // a stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(target_requested)
            && $stable(target_khz) && $stable(new_index))
        else $error("result changed while stalled");

    // no frequency is reported without a request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !target_requested |-> target_khz == 24'd0)
        else $error("target_khz nonzero without request");

    // an accepted sample keeps the input side busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !op |=> !in_ready)
        else $error("ready right after a sample transaction");

    // a result appears only at the end of a busy span
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without a sample in progress");

endmodule

bind load_stepped_dvfs_governor lsdg_checker u_lsdg_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for load_stepped_dvfs_governor: a queued valid/ready driver, a result
// monitor and a per-transaction model of the table scan, the thresholds and the rate pacing.
// Depends on lsdg_pkg and the governor RTL.

module testbench;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int IDLE_PCT      = 18;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 34;
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [6:0]  load;
        logic [23:0] khz;
        logic [3:0]  slot;
        logic        ev;
    } gov_item_t;

    typedef struct packed {
        logic        req;
        logic [23:0] khz;
        logic [3:0]  idx;
    } gov_decision_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        op = OP_SAMPLE;
    logic [6:0]  load_percent = '0;
    logic [23:0] frequency_khz = '0;
    logic [3:0]  entry_index = '0;
    logic        entry_valid = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        target_requested;
    logic [23:0] target_khz;
    logic [3:0]  new_index;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [27:0] cfg_data = '0;

    // predictor state
    logic [27:0] gov_cfg [8] = '{28'(lsdg_pkg::RESP_RESET), lsdg_pkg::THRESH_RESET,
                                 28'(lsdg_pkg::PUMP_RESET),
                                 28'd1, 28'd1, 28'd0, 28'd15, 28'd16};
    logic [23:0] khz_tbl [lsdg_pkg::TABLE_DEPTH];
    logic        valid_tbl [lsdg_pkg::TABLE_DEPTH] = '{default: 1'b0};
    int          up_count = 0;
    int          down_count = 0;

    // stimulus side
    gov_item_t     items_queued [$];
    gov_decision_t decisions_due [$];
    logic [23:0]   stim_khz [lsdg_pkg::TABLE_DEPTH] = '{default: 24'd0};
    bit            calm = 1'b0;

    int cycle_count = 0;
    int mismatch_count = 0;
    int n_results = 0;
    int n_targets = 0;
    int n_writes = 0;
    int n_settings = 0;

    load_stepped_dvfs_governor uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .load_percent     (load_percent),
        .frequency_khz    (frequency_khz),
        .entry_index      (entry_index),
        .entry_valid      (entry_valid),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .target_requested (target_requested),
        .target_khz       (target_khz),
        .new_index        (new_index),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Saturate a pump step field to 1..6.
    function automatic int pump_field(int pos);
        int s;
        s = int'(gov_cfg[lsdg_pkg::CFG_PUMP][3*pos +: 3]);
        if (s == 0)
            s = 1;
        if (s == 7)
            s = 6;
        return s;
    endfunction

    // Apply one transaction to the predictor; returns 1 when it yields a decision.
    function automatic bit govern_transaction(input gov_item_t it, output gov_decision_t d);
        int  len, idx, band, raise_th, lower_th, up_step, down_step, up_div, down_div, lo, hi;
        bit  stepped;
        d = '0;
        stepped = 1'b0;
        if (it.op == OP_WRITE)
        begin
            khz_tbl[it.slot] = it.khz;
            valid_tbl[it.slot] = it.ev;
            return 1'b0;
        end
        len = int'(gov_cfg[lsdg_pkg::CFG_TBL_LEN][4:0]);
        if (len > lsdg_pkg::TABLE_DEPTH)
            len = lsdg_pkg::TABLE_DEPTH;
        idx = 0;
        // first valid match wins: scan downward so the lowest slot is kept
        for (int i = len - 1; i >= 0; i--)
            if (valid_tbl[i] && khz_tbl[i] == it.khz)
                idx = i;
        band = (it.khz < gov_cfg[lsdg_pkg::CFG_RESP][23:0]) ? 1 : 0;
        raise_th = int'(gov_cfg[lsdg_pkg::CFG_THRESH][14*band +: 7]);
        lower_th = int'(gov_cfg[lsdg_pkg::CFG_THRESH][14*band + 7 +: 7]);
        up_step = pump_field(band);
        down_step = pump_field(2 + band);
        up_div = (gov_cfg[lsdg_pkg::CFG_UP_DIV][7:0] == 8'd0)
               ? 1 : int'(gov_cfg[lsdg_pkg::CFG_UP_DIV][7:0]);
        down_div = (gov_cfg[lsdg_pkg::CFG_DN_DIV][7:0] == 8'd0)
                 ? 1 : int'(gov_cfg[lsdg_pkg::CFG_DN_DIV][7:0]);
        lo = int'(gov_cfg[lsdg_pkg::CFG_LO_IDX][3:0]);
        hi = int'(gov_cfg[lsdg_pkg::CFG_HI_IDX][3:0]);
        if (int'(it.load) >= raise_th && idx < hi)
        begin
            if (up_count % up_div == 0)
            begin
                idx = (idx + up_step <= hi) ? idx + up_step : hi;
                stepped = 1'b1;
            end
            else if (up_count < up_div)
                up_count++;
            else
                up_count = 1;
        end
        else if (int'(it.load) < lower_th && idx > lo)
        begin
            if (down_count % down_div == 0)
            begin
                idx = (idx - lo >= down_step) ? idx - down_step : lo;
                stepped = 1'b1;
            end
            else if (down_count < down_div)
                down_count++;
            else
                down_count = 1;
        end
        else
        begin
            up_count = 1;
            down_count = 1;
        end
        if (stepped)
        begin
            up_count = 1;
            down_count = 1;
            if (idx < len && valid_tbl[idx])
            begin
                d.req = 1'b1;
                d.khz = khz_tbl[idx];
            end
        end
        d.idx = 4'(idx);
        return 1'b1;
    endfunction

    // Input channel: hold the payload until accepted, then advance to the next queued item.
    always @(posedge clk or negedge rst_n)
    begin : stimulus_driver
        gov_item_t     taken;
        gov_item_t     nxt;
        gov_decision_t d;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                taken = {op, load_percent, frequency_khz, entry_index, entry_valid};
                if (govern_transaction(taken, d))
                    decisions_due.push_back(d);
                else
                    n_writes++;
            end
            if (!in_valid || in_ready)
            begin
                if (items_queued.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = items_queued.pop_front();
                    in_valid <= 1'b1;
                    op <= nxt.op;
                    load_percent <= nxt.load;
                    frequency_khz <= nxt.khz;
                    entry_index <= nxt.slot;
                    entry_valid <= nxt.ev;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output channel: compare each transaction with the oldest decision due.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        gov_decision_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (decisions_due.size() == 0)
                    report_mismatch("result transaction with no sample outstanding");
                else
                begin
                    want = decisions_due.pop_front();
                    n_results++;
                    if (want.req)
                        n_targets++;
                    if (target_requested !== want.req)
                        report_mismatch($sformatf("target_requested got %b want %b",
                                                  target_requested, want.req));
                    if (target_khz !== want.khz)
                        report_mismatch($sformatf("target_khz got %0d want %0d",
                                                  target_khz, want.khz));
                    if (new_index !== want.idx)
                        report_mismatch($sformatf("new_index got %0d want %0d",
                                                  new_index, want.idx));
                end
            end
            out_ready <= calm || $urandom_range(99) >= IDLE_PCT;
        end
    end

    function automatic void push_write(logic [3:0] slot, logic [23:0] khz, logic ev);
        items_queued.push_back('{op: OP_WRITE, load: 7'($urandom), khz: khz, slot: slot,
                                 ev: ev});
        stim_khz[slot] = khz;
    endfunction

    function automatic void push_sample(logic [6:0] load, logic [23:0] khz);
        items_queued.push_back('{op: OP_SAMPLE, load: load, khz: khz, slot: 4'($urandom),
                                 ev: 1'($urandom)});
    endfunction

    // Ascending table with an occasional repeated value and invalid slot.
    function automatic void fill_table();
        logic [23:0] khz;
        khz = 24'($urandom_range(100000, 400000));
        for (int s = 0; s < lsdg_pkg::TABLE_DEPTH; s++)
        begin
            if ($urandom_range(99) >= 5)
                khz += 24'($urandom_range(40000, 160000));
            push_write(4'(s), khz, $urandom_range(99) < 90);
        end
    endfunction

    function automatic logic [7:0] pick_divisor();
        case ($urandom_range(4))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd2;
            3: return 8'd3;
            default: return 8'($urandom_range(4, 8));
        endcase
    endfunction

    // Mostly runs of same-direction load on a tabled frequency, to drive the rate counters.
    function automatic void random_phase(int n_items);
        int          made, kind, dir, run;
        logic [23:0] khz;
        logic [6:0]  load;
        made = 0;
        while (made < n_items)
        begin
            kind = $urandom_range(99);
            if (kind < 10)
            begin
                khz = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(100000, 3000000));
                push_write(4'($urandom), khz, $urandom_range(99) < 80);
                made++;
            end
            else if (kind < 20)
            begin
                push_sample(7'($urandom), 24'($urandom));
                made++;
            end
            else
            begin
                khz = stim_khz[$urandom_range(lsdg_pkg::TABLE_DEPTH - 1)];
                dir = $urandom_range(2);
                run = $urandom_range(1, 6);
                repeat (run)
                begin
                    case (dir)
                        0: load = ($urandom_range(99) < 5) ? 7'($urandom_range(101, 127))
                                                           : 7'($urandom_range(85, 100));
                        1: load = 7'($urandom_range(15));
                        default: load = 7'($urandom_range(30, 70));
                    endcase
                    push_sample(load, khz);
                    made++;
                end
            end
        end
    endfunction

    task automatic write_reg(lsdg_pkg::cfg_idx_t which, logic [27:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        gov_cfg[which] = value;
    endtask

    task automatic program_all(logic [23:0] resp, logic [27:0] thr, logic [11:0] pump,
                               logic [7:0] up_div, logic [7:0] dn_div,
                               logic [3:0] lo, logic [3:0] hi, logic [4:0] len);
        write_reg(lsdg_pkg::CFG_RESP, 28'(resp));
        write_reg(lsdg_pkg::CFG_THRESH, thr);
        write_reg(lsdg_pkg::CFG_PUMP, 28'(pump));
        write_reg(lsdg_pkg::CFG_UP_DIV, 28'(up_div));
        write_reg(lsdg_pkg::CFG_DN_DIV, 28'(dn_div));
        write_reg(lsdg_pkg::CFG_LO_IDX, 28'(lo));
        write_reg(lsdg_pkg::CFG_HI_IDX, 28'(hi));
        write_reg(lsdg_pkg::CFG_TBL_LEN, 28'(len));
        @(posedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic program_random();
        logic [27:0] thr;
        logic [23:0] resp;
        logic [3:0]  lo, hi;
        logic [4:0]  len;
        thr = {7'($urandom_range(10, 50)), 7'($urandom_range(50, 90)),
               7'($urandom_range(10, 50)), 7'($urandom_range(50, 90))};
        if ($urandom_range(99) < 20)
            thr = 28'($urandom);
        resp = ($urandom_range(99) < 80) ? stim_khz[$urandom_range(lsdg_pkg::TABLE_DEPTH - 1)]
                                         : 24'($urandom);
        lo = 4'($urandom_range(5));
        hi = 4'($urandom_range(9, 15));
        if ($urandom_range(99) < 10)
        begin
            lo = 4'($urandom);
            hi = 4'($urandom);
        end
        len = ($urandom_range(99) < 75) ? 5'd16 : 5'($urandom);
        program_all(resp, thr, 12'($urandom), pick_divisor(), pick_divisor(), lo, hi, len);
    endtask

    // Drain: wait for the queue, the input channel and every decision, then let the block settle.
    task automatic wait_idle();
        while (items_queued.size() != 0 || in_valid || decisions_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : run_sequence
        int calm_phase;
        calm_phase = $urandom_range(9);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: repeated value in slots 8 and 9, invalid slot 6, both frequency extremes
        for (int s = 0; s < lsdg_pkg::TABLE_DEPTH; s++)
            push_write(4'(s), (s == 15) ? 24'hFFFFFF : (s == 9) ? 24'd1200000
                                                              : 24'(150000 * s), s != 6);
        push_sample(7'd100, 24'd0);
        push_sample(7'd0, 24'hFFFFFF);
        push_sample(7'd127, 24'd1200000);
        push_sample(7'd65, 24'd1800000);
        push_sample(7'd100, 24'd777777);
        push_sample(7'd100, 24'd600000);
        push_sample(7'd0, 24'd0);
        push_sample(7'd100, 24'hFFFFFF);
        push_sample(7'd69, 24'd1050000);
        wait_idle();

        program_all(24'd0, 28'd0, 12'd0, 8'd0, 8'd0, 4'd0, 4'd15, 5'd0);
        random_phase(PHASE_ITEMS);
        wait_idle();
        program_all(24'hFFFFFF, 28'hFFFFFFF, 12'hFFF, 8'd255, 8'd255, 4'd0, 4'd15, 5'd31);
        random_phase(PHASE_ITEMS);
        wait_idle();
        // inverted policy bounds, length past the table depth
        program_all(stim_khz[7], lsdg_pkg::THRESH_RESET, lsdg_pkg::PUMP_RESET, 8'd2, 8'd3,
                    4'd12, 4'd3, 5'd17);
        random_phase(PHASE_ITEMS);
        wait_idle();

        for (int p = 0; p < 10; p++)
        begin
            calm = (p == calm_phase);
            program_random();
            if (p % 3 == 0)
                fill_table();
            random_phase(PHASE_ITEMS);
            wait_idle();
        end
        calm = 1'b0;

        $display("run covered %0d table writes and %0d load samples under %0d settings",
                 n_writes, n_results, n_settings);
        $display("%0d samples stepped to a usable entry, %0d mismatches",
                 n_targets, mismatch_count);
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
